/* rtl/rpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative permeability curves: shared package
// Fixed point constants, item tags, config types and the constant tables
// for the base-2 exponent chain.
// ----------------------------------------------------------------------------
package rpc_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int IG         = 30;
   localparam int SAT_W      = FRAC_BITS + 1;
   localparam int COEF_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int DIV_STAGES = FRAC_BITS / 2;
   localparam int ACC_W      = IG + 1;
   localparam int T_W        = IG + 5;
   localparam int E_W        = 43;
   localparam int WQ_W       = 39;
   localparam int W_W        = IG + 6;
   localparam int V_W        = IG + 8;
   localparam int AUX_W      = 8;

   localparam logic [SAT_W-1:0] ONE     = SAT_W'(1) << FRAC_BITS;
   localparam logic [ACC_W-1:0] LOG2E   = 31'd1549082005;
   localparam logic [W_W-1:0]   W_CAP   = W_W'(32) << IG;
   localparam logic [31:0]      G_UNITY = 32'h8000_0000;

   typedef enum logic [1:0] {
      MODE_NORM,
      MODE_ZERO,
      MODE_LOW,
      MODE_HIGH
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WATER_A,
      CSR_WATER_B,
      CSR_OIL_A,
      CSR_OIL_B,
      CSR_IRR_WATER,
      CSR_RES_OIL,
      CSR_WATER_END,
      CSR_OIL_END
   } csr_index_type;

   typedef struct packed {
      mode_type         mode;
      logic [AUX_W-1:0] aux;
   } tag_type;

   typedef struct packed {
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [SAT_W-1:0]  maxv;
   } curve_cfg_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] b;
      int          k;
      rem = val;
      res = '0;
      b   = 64'd1 << 62;
      for (k = 0; k < 32; k++) begin
         if (b > rem) b = b >> 2;
      end
      for (k = 0; k < 32; k++) begin
         if (b != '0) begin
            if (rem >= res + b) begin
               rem = rem - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
      end
      return res;
   endfunction

   // 2^(2^-idx) in Q.IG
   function automatic logic [ACC_W-1:0] exp2_root(input int idx);
      logic [63:0] r;
      int          k;
      r = 64'd1 << (IG + 1);
      for (k = 1; k <= IG; k++) begin
         if (k <= idx) r = isqrt64(r << IG);
      end
      return r[ACC_W-1:0];
   endfunction

endpackage

/* rtl/rpc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturation normalizer
// Restoring divider, two quotient bits per stage: x = (num << 16) / span.
// ----------------------------------------------------------------------------
module rpc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [rpc_pkg::FRAC_BITS-1:0]  in_num,
   input  logic [rpc_pkg::SAT_W-1:0]      in_span,
   input  rpc_pkg::mode_type              in_mode,
   output logic                           out_valid,
   output logic [rpc_pkg::FRAC_BITS-1:0]  out_x,
   output rpc_pkg::mode_type              out_mode
);

   localparam int N = rpc_pkg::DIV_STAGES;
   localparam int S = rpc_pkg::SAT_W;

   logic                          valid_ff [1:N];
   logic [S-1:0]                  rem_ff   [1:N];
   logic [S-1:0]                  span_ff  [1:N];
   logic [rpc_pkg::FRAC_BITS-1:0] q_ff     [1:N];
   rpc_pkg::mode_type             mode_ff  [1:N];

   for (genvar i = 1; i <= N; i++) begin : g_stage
      logic                          valid_src;
      logic [S-1:0]                  rem_src;
      logic [S-1:0]                  span_src;
      logic [rpc_pkg::FRAC_BITS-1:0] q_src;
      rpc_pkg::mode_type             mode_src;
      logic [S:0]                    r1;
      logic [S:0]                    r2;
      logic                          b1;
      logic                          b0;
      logic [S-1:0]                  rem_in;
      logic [rpc_pkg::FRAC_BITS-1:0] q_in;

      if (i == 1) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = S'(in_num);
         assign span_src  = in_span;
         assign q_src     = '0;
         assign mode_src  = in_mode;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign span_src  = span_ff[i-1];
         assign q_src     = q_ff[i-1];
         assign mode_src  = mode_ff[i-1];
      end

      always_comb begin
         r1 = {rem_src, 1'b0};
         b1 = (r1 >= (S+1)'(span_src));
         if (b1) r1 = r1 - (S+1)'(span_src);
         r2 = {r1[S-1:0], 1'b0};
         b0 = (r2 >= (S+1)'(span_src));
         if (b0) r2 = r2 - (S+1)'(span_src);
         rem_in = r2[S-1:0];
         q_in   = {q_src[rpc_pkg::FRAC_BITS-3:0], b1, b0};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            span_ff[i] <= span_src;
            q_ff[i]    <= q_in;
            mode_ff[i] <= mode_src;
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_x     = q_ff[N];
   assign out_mode  = mode_ff[N];

endmodule

/* rtl/rpc_log2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Negative base-2 logarithm
// t = -log2(u / 2^16) in Q.30, one fraction bit per squaring stage.
// ----------------------------------------------------------------------------
module rpc_log2 (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [rpc_pkg::FRAC_BITS-1:0]  in_u,
   input  rpc_pkg::tag_type               in_tag,
   output logic                           out_valid,
   output logic [rpc_pkg::T_W-1:0]        out_t,
   output rpc_pkg::tag_type               out_tag
);

   localparam int IG = rpc_pkg::IG;
   localparam int AW = rpc_pkg::ACC_W;

   logic [3:0]             p_in;
   logic [AW-1:0]          z_in;

   logic                   valid_ff [0:IG];
   logic [3:0]             p_ff     [0:IG];
   logic [AW-1:0]          z_ff     [0:IG];
   logic [IG-1:0]          frac_ff  [0:IG];
   rpc_pkg::tag_type       tag_ff   [0:IG];

   logic                   t_valid_ff;
   logic [rpc_pkg::T_W-1:0] t_ff;
   logic [rpc_pkg::T_W-1:0] t_in;
   rpc_pkg::tag_type       t_tag_ff;

   always_comb begin
      p_in = '0;
      for (int k = 1; k < rpc_pkg::FRAC_BITS; k++) begin
         if (in_u[k]) p_in = 4'(k);
      end
      z_in = AW'(in_u) << (5'(IG) - {1'b0, p_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0]    <= p_in;
         z_ff[0]    <= z_in;
         frac_ff[0] <= '0;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar i = 1; i <= IG; i++) begin : g_stage
      localparam logic [IG-1:0] FBIT = IG'(1) << (IG - i);
      logic [2*AW-1:0] sq;
      logic [AW:0]     hi;
      logic [AW-1:0]   z_in_i;
      logic [IG-1:0]   frac_in_i;

      always_comb begin
         sq        = (2*AW)'(z_ff[i-1]) * (2*AW)'(z_ff[i-1]);
         hi        = sq[IG +: AW+1];
         z_in_i    = hi[AW] ? hi[AW:1] : hi[AW-1:0];
         frac_in_i = hi[AW] ? (frac_ff[i-1] | FBIT) : frac_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[i]    <= p_ff[i-1];
            z_ff[i]    <= z_in_i;
            frac_ff[i] <= frac_in_i;
            tag_ff[i]  <= tag_ff[i-1];
         end
      end
   end

   assign t_in = (rpc_pkg::T_W'(5'(rpc_pkg::FRAC_BITS) - {1'b0, p_ff[IG]}) << IG)
                 - rpc_pkg::T_W'(frac_ff[IG]);

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (en) begin
         t_valid_ff <= valid_ff[IG];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff     <= t_in;
         t_tag_ff <= tag_ff[IG];
      end
   end

   assign out_valid = t_valid_ff;
   assign out_t     = t_ff;
   assign out_tag   = t_tag_ff;

endmodule

/* rtl/rpc_exp2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional base-2 exponent
// acc = 2^(f / 2^30) in Q.30, one conditional root multiply per stage.
// ----------------------------------------------------------------------------
module rpc_exp2 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [rpc_pkg::IG-1:0]      in_f,
   input  rpc_pkg::tag_type            in_tag,
   output logic                        out_valid,
   output logic [rpc_pkg::ACC_W-1:0]   out_acc,
   output rpc_pkg::tag_type            out_tag
);

   localparam int IG = rpc_pkg::IG;
   localparam int AW = rpc_pkg::ACC_W;

   logic              valid_ff [1:IG];
   logic [AW-1:0]     acc_ff   [1:IG];
   logic [IG-1:0]     f_ff     [1:IG];
   rpc_pkg::tag_type  tag_ff   [1:IG];

   for (genvar i = 1; i <= IG; i++) begin : g_stage
      localparam logic [AW-1:0] ROOT = rpc_pkg::exp2_root(i);
      logic              valid_src;
      logic [AW-1:0]     acc_src;
      logic [IG-1:0]     f_src;
      rpc_pkg::tag_type  tag_src;
      logic [2*AW-1:0]   prod;
      logic [AW-1:0]     acc_in;

      if (i == 1) begin : g_first
         assign valid_src = in_valid;
         assign acc_src   = AW'(1) << IG;
         assign f_src     = in_f;
         assign tag_src   = in_tag;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign acc_src   = acc_ff[i-1];
         assign f_src     = f_ff[i-1];
         assign tag_src   = tag_ff[i-1];
      end

      assign prod   = (2*AW)'(acc_src) * (2*AW)'(ROOT);
      assign acc_in = f_src[IG-i] ? prod[IG +: AW] : acc_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[i] <= acc_in;
            f_ff[i]   <= f_src;
            tag_ff[i] <= tag_src;
         end
      end
   end

   assign out_valid = valid_ff[IG];
   assign out_acc   = acc_ff[IG];
   assign out_tag   = tag_ff[IG];

endmodule

/* rtl/rpc_curve.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponential permeability curve
// kr = max * exp(-A * u^(-B)) through log2, scale, exp2 and rounding stages.
// ----------------------------------------------------------------------------
module rpc_curve (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  rpc_pkg::curve_cfg_type         cfg,
   input  logic                           in_valid,
   input  logic [rpc_pkg::FRAC_BITS-1:0]  in_u,
   input  rpc_pkg::mode_type              in_mode,
   output logic                           out_valid,
   output logic [rpc_pkg::SAT_W-1:0]      out_kr,
   output rpc_pkg::mode_type              out_mode
);

   localparam int IG = rpc_pkg::IG;
   localparam int AW = rpc_pkg::ACC_W;
   localparam int CW = rpc_pkg::COEF_W;

   rpc_pkg::tag_type           in_tag;
   logic                       lg_valid;
   logic [rpc_pkg::T_W-1:0]    lg_t;
   rpc_pkg::tag_type           lg_tag;

   logic                       m1_valid_ff;
   logic [41:0]                m1_lo_ff;
   logic [40:0]                m1_hi_ff;
   rpc_pkg::tag_type           m1_tag_ff;

   logic [58:0]                m2_sum;
   logic [rpc_pkg::E_W-1:0]    m2_e;
   logic [12:0]                m2_n;
   logic                       m2_valid_ff;
   logic [IG-1:0]              m2_f_ff;
   rpc_pkg::tag_type           m2_tag_ff;
   rpc_pkg::tag_type           m2_tag_in;

   logic                       x1_valid;
   logic [AW-1:0]              x1_acc;
   rpc_pkg::tag_type           x1_tag;

   logic [54:0]                w1_prod;
   logic                       w1_valid_ff;
   logic [rpc_pkg::WQ_W-1:0]   w1_wq_ff;
   rpc_pkg::tag_type           w1_tag_ff;

   logic [5:0]                 w2_n;
   logic [rpc_pkg::W_W-1:0]    w2_lim;
   logic [rpc_pkg::W_W-1:0]    w2_w_in;
   logic                       w2_valid_ff;
   logic [rpc_pkg::W_W-1:0]    w2_w_ff;
   rpc_pkg::tag_type           w2_tag_ff;

   logic [60:0]                v1_pl;
   logic                       v1_valid_ff;
   logic [36:0]                v1_ph_ff;
   logic [AW-1:0]              v1_pl_ff;
   rpc_pkg::tag_type           v1_tag_ff;

   logic [rpc_pkg::V_W-1:0]    v2_v;
   logic [7:0]                 v2_nv;
   logic [IG-1:0]              v2_fv;
   logic                       v2_valid_ff;
   logic [IG-1:0]              v2_f_ff;
   rpc_pkg::tag_type           v2_tag_ff;
   rpc_pkg::tag_type           v2_tag_in;

   logic                       x2_valid;
   logic [AW-1:0]              x2_acc;
   rpc_pkg::tag_type           x2_tag;

   logic [31:0]                r1_g;
   logic                       r1_valid_ff;
   logic [48:0]                r1_prod_ff;
   rpc_pkg::tag_type           r1_tag_ff;

   logic [5:0]                 r2_sh;
   logic [62:0]                r2_sum;
   logic [62:0]                r2_r;
   logic [rpc_pkg::SAT_W-1:0]  r2_kr_in;
   logic                       r2_valid_ff;
   logic [rpc_pkg::SAT_W-1:0]  r2_kr_ff;
   rpc_pkg::mode_type          r2_mode_ff;

   assign in_tag.mode = in_mode;
   assign in_tag.aux  = '0;

   rpc_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .in_u      (in_u),
      .in_tag    (in_tag),
      .out_valid (lg_valid),
      .out_t     (lg_t),
      .out_tag   (lg_tag)
   );

   // scale log by exponent B, split in two partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= lg_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_lo_ff  <= 42'(cfg.b) * 42'(lg_t[17:0]);
         m1_hi_ff  <= 41'(cfg.b) * 41'(lg_t[rpc_pkg::T_W-1:18]);
         m1_tag_ff <= lg_tag;
      end
   end

   always_comb begin
      m2_sum         = 59'({m1_hi_ff, 18'b0}) + 59'(m1_lo_ff);
      m2_e           = m2_sum[58:16];
      m2_n           = m2_e[rpc_pkg::E_W-1:IG];
      m2_tag_in.mode = m1_tag_ff.mode;
      m2_tag_in.aux  = {(m2_n >= 13'd37), 1'b0, m2_n[5:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_f_ff   <= m2_e[IG-1:0];
         m2_tag_ff <= m2_tag_in;
      end
   end

   rpc_exp2 u_exp2_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m2_valid_ff),
      .in_f      (m2_f_ff),
      .in_tag    (m2_tag_ff),
      .out_valid (x1_valid),
      .out_acc   (x1_acc),
      .out_tag   (x1_tag)
   );

   assign w1_prod = 55'(cfg.a) * 55'(x1_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_valid_ff <= 1'b0;
      end else if (en) begin
         w1_valid_ff <= x1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_wq_ff  <= w1_prod[54:rpc_pkg::FRAC_BITS];
         w1_tag_ff <= x1_tag;
      end
   end

   // apply integer exponent, saturate at 32.0
   always_comb begin
      w2_n   = w1_tag_ff.aux[5:0];
      w2_lim = rpc_pkg::W_CAP >> w2_n;
      if (w1_tag_ff.aux[7] || (w1_wq_ff > rpc_pkg::WQ_W'(w2_lim))) begin
         w2_w_in = rpc_pkg::W_CAP;
      end else begin
         w2_w_in = rpc_pkg::W_W'(w1_wq_ff) << w2_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w2_valid_ff <= 1'b0;
      end else if (en) begin
         w2_valid_ff <= w1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w2_w_ff   <= w2_w_in;
         w2_tag_ff <= w1_tag_ff;
      end
   end

   assign v1_pl = 61'(w2_w_ff[IG-1:0]) * 61'(rpc_pkg::LOG2E);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_valid_ff <= 1'b0;
      end else if (en) begin
         v1_valid_ff <= w2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ph_ff  <= 37'(w2_w_ff[rpc_pkg::W_W-1:IG]) * 37'(rpc_pkg::LOG2E);
         v1_pl_ff  <= v1_pl[60:IG];
         v1_tag_ff <= w2_tag_ff;
      end
   end

   always_comb begin
      v2_v = rpc_pkg::V_W'(v1_ph_ff) + rpc_pkg::V_W'(v1_pl_ff);
      if (cfg.a == '0) v2_v = '0;
      v2_nv          = v2_v[rpc_pkg::V_W-1:IG];
      v2_fv          = v2_v[IG-1:0];
      v2_tag_in.mode = v1_tag_ff.mode;
      v2_tag_in.aux  = {(v2_nv >= 8'd32), (v2_fv == '0), 1'b0, v2_nv[4:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_valid_ff <= 1'b0;
      end else if (en) begin
         v2_valid_ff <= v1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v2_f_ff   <= ~v2_fv + IG'(1);
         v2_tag_ff <= v2_tag_in;
      end
   end

   rpc_exp2 u_exp2_decay (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_valid_ff),
      .in_f      (v2_f_ff),
      .in_tag    (v2_tag_ff),
      .out_valid (x2_valid),
      .out_acc   (x2_acc),
      .out_tag   (x2_tag)
   );

   assign r1_g = x2_tag.aux[6] ? rpc_pkg::G_UNITY : 32'(x2_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
      end else if (en) begin
         r1_valid_ff <= x2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_prod_ff <= 49'(cfg.maxv) * 49'(r1_g);
         r1_tag_ff  <= x2_tag;
      end
   end

   // round half up, saturate at one, force zero when the decay exponent reaches 32
   always_comb begin
      r2_sh  = 6'(IG + 1) + {1'b0, r1_tag_ff.aux[4:0]};
      r2_sum = 63'(r1_prod_ff) + (63'd1 << (r2_sh - 6'd1));
      r2_r   = r2_sum >> r2_sh;
      if (r1_tag_ff.aux[7]) begin
         r2_kr_in = '0;
      end else if (r2_r > 63'(rpc_pkg::ONE)) begin
         r2_kr_in = rpc_pkg::ONE;
      end else begin
         r2_kr_in = r2_r[rpc_pkg::SAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_valid_ff <= 1'b0;
      end else if (en) begin
         r2_valid_ff <= r1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_kr_ff   <= r2_kr_in;
         r2_mode_ff <= r1_tag_ff.mode;
      end
   end

   assign out_valid = r2_valid_ff;
   assign out_kr    = r2_kr_ff;
   assign out_mode  = r2_mode_ff;

endmodule

/* rtl/relative_permeability_curves_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative permeability curves: top level
// Pipeline: 1 prep stage, 8 divider stages, 100 curve stages and 1 output
// register between word acceptance and rsp_valid.
// Throughput: one word per cycle; the whole pipeline holds when the output
// register is full and rsp_ready is low.
// Reset: synchronous; clears all valid bits and the config registers to 0.
// ----------------------------------------------------------------------------
module relative_permeability_curves_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rpc_pkg::SAT_W-1:0]         req_water_saturation,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rpc_pkg::SAT_W-1:0]         rsp_water_rel_perm,
   output logic [rpc_pkg::SAT_W-1:0]         rsp_oil_rel_perm,
   input  logic                              csr_we,
   input  logic [rpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rpc_pkg::COEF_W-1:0]        csr_wdata
);

   localparam int S = rpc_pkg::SAT_W;

   logic [rpc_pkg::COEF_W-1:0] water_a_ff, water_b_ff, oil_a_ff, oil_b_ff;
   logic [S-1:0]               irr_water_ff, res_oil_ff, water_end_ff, oil_end_ff;

   logic [S-1:0]               wmax;
   logic [S-1:0]               omax;
   rpc_pkg::curve_cfg_type     water_cfg;
   rpc_pkg::curve_cfg_type     oil_cfg;

   logic                       en;

   logic signed [S+1:0]        span_s;
   logic signed [S+1:0]        num_s;
   rpc_pkg::mode_type          mode_in;
   logic                       prep_valid_ff;
   logic [rpc_pkg::FRAC_BITS-1:0] prep_num_ff;
   logic [S-1:0]               prep_span_ff;
   rpc_pkg::mode_type          prep_mode_ff;

   logic                       div_valid;
   logic [rpc_pkg::FRAC_BITS-1:0] div_x;
   rpc_pkg::mode_type          div_mode;
   logic [rpc_pkg::FRAC_BITS-1:0] oil_u;

   logic                       cw_valid, co_valid;
   logic [S-1:0]               cw_kr, co_kr;
   rpc_pkg::mode_type          cw_mode, co_mode;

   logic                       rsp_valid_ff;
   logic [S-1:0]               rsp_water_ff, rsp_oil_ff;
   logic [S-1:0]               rsp_water_in, rsp_oil_in;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         water_a_ff   <= '0;
         water_b_ff   <= '0;
         oil_a_ff     <= '0;
         oil_b_ff     <= '0;
         irr_water_ff <= '0;
         res_oil_ff   <= '0;
         water_end_ff <= '0;
         oil_end_ff   <= '0;
      end else if (csr_we) begin
         case (rpc_pkg::csr_index_type'(csr_index))
            rpc_pkg::CSR_WATER_A:   water_a_ff   <= csr_wdata;
            rpc_pkg::CSR_WATER_B:   water_b_ff   <= csr_wdata;
            rpc_pkg::CSR_OIL_A:     oil_a_ff     <= csr_wdata;
            rpc_pkg::CSR_OIL_B:     oil_b_ff     <= csr_wdata;
            rpc_pkg::CSR_IRR_WATER: irr_water_ff <= csr_wdata[S-1:0];
            rpc_pkg::CSR_RES_OIL:   res_oil_ff   <= csr_wdata[S-1:0];
            rpc_pkg::CSR_WATER_END: water_end_ff <= csr_wdata[S-1:0];
            rpc_pkg::CSR_OIL_END:   oil_end_ff   <= csr_wdata[S-1:0];
            default: ;
         endcase
      end
   end

   assign wmax = (water_end_ff > rpc_pkg::ONE) ? rpc_pkg::ONE : water_end_ff;
   assign omax = (oil_end_ff > rpc_pkg::ONE) ? rpc_pkg::ONE : oil_end_ff;

   assign water_cfg.a    = water_a_ff;
   assign water_cfg.b    = water_b_ff;
   assign water_cfg.maxv = wmax;
   assign oil_cfg.a      = oil_a_ff;
   assign oil_cfg.b      = oil_b_ff;
   assign oil_cfg.maxv   = omax;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // classify the word and form the normalization operands
   always_comb begin
      span_s = $signed((S+2)'(rpc_pkg::ONE)) - $signed({2'b0, irr_water_ff})
               - $signed({2'b0, res_oil_ff});
      num_s  = $signed({2'b0, req_water_saturation}) - $signed({2'b0, irr_water_ff});
      if (span_s <= 0) begin
         mode_in = rpc_pkg::MODE_ZERO;
      end else if (num_s <= 0) begin
         mode_in = rpc_pkg::MODE_LOW;
      end else if (num_s >= span_s) begin
         mode_in = rpc_pkg::MODE_HIGH;
      end else begin
         mode_in = rpc_pkg::MODE_NORM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (en) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_num_ff  <= num_s[rpc_pkg::FRAC_BITS-1:0];
         prep_span_ff <= span_s[S-1:0];
         prep_mode_ff <= mode_in;
      end
   end

   rpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid_ff),
      .in_num    (prep_num_ff),
      .in_span   (prep_span_ff),
      .in_mode   (prep_mode_ff),
      .out_valid (div_valid),
      .out_x     (div_x),
      .out_mode  (div_mode)
   );

   assign oil_u = ~div_x + rpc_pkg::FRAC_BITS'(1);

   rpc_curve u_water (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (water_cfg),
      .in_valid  (div_valid),
      .in_u      (div_x),
      .in_mode   (div_mode),
      .out_valid (cw_valid),
      .out_kr    (cw_kr),
      .out_mode  (cw_mode)
   );

   rpc_curve u_oil (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (oil_cfg),
      .in_valid  (div_valid),
      .in_u      (oil_u),
      .in_mode   (div_mode),
      .out_valid (co_valid),
      .out_kr    (co_kr),
      .out_mode  (co_mode)
   );

   always_comb begin
      case (cw_mode)
         rpc_pkg::MODE_NORM: begin
            rsp_water_in = cw_kr;
            rsp_oil_in   = co_kr;
         end
         rpc_pkg::MODE_LOW: begin
            rsp_water_in = '0;
            rsp_oil_in   = omax;
         end
         rpc_pkg::MODE_HIGH: begin
            rsp_water_in = wmax;
            rsp_oil_in   = '0;
         end
         default: begin
            rsp_water_in = '0;
            rsp_oil_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cw_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_water_ff <= rsp_water_in;
         rsp_oil_ff   <= rsp_oil_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_water_rel_perm = rsp_water_ff;
   assign rsp_oil_rel_perm   = rsp_oil_ff;

   a_curve_valid_match: assert property (@(posedge clock) disable iff (reset)
      cw_valid == co_valid)
      else $error("curve pipelines out of step");

   a_curve_mode_match: assert property (@(posedge clock) disable iff (reset)
      cw_valid |-> (cw_mode == co_mode))
      else $error("curve word classes differ");

   a_rsp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_water_rel_perm <= rpc_pkg::ONE && rsp_oil_rel_perm <= rpc_pkg::ONE))
      else $error("result above one");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while output stalled");

endmodule

/* tb/rpc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative permeability curves: checker
// Mirrors the config registers, predicts water and oil relative permeability
// for every accepted request word and compares each accepted response word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rpc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [rpc_pkg::SAT_W-1:0]     req_water_saturation,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [rpc_pkg::SAT_W-1:0]     rsp_water_rel_perm,
   input  logic [rpc_pkg::SAT_W-1:0]     rsp_oil_rel_perm,
   input  logic                          csr_we,
   input  logic [rpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rpc_pkg::COEF_W-1:0]    csr_wdata,
   output int                            failures,
   output int                            pending
);
   import rpc_pkg::*;

   typedef struct {
      logic [SAT_W-1:0] water;
      logic [SAT_W-1:0] oil;
   } perm_pair_type;

   perm_pair_type     perm_queue[$];
   logic [63:0]       half_roots[1:IG];
   logic [COEF_W-1:0] water_a, water_b, oil_a, oil_b;
   logic [SAT_W-1:0]  irr_water, res_oil, water_max, oil_max;

   function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bt;
      rem = val;
      res = '0;
      bt  = 64'd1 << 62;
      while (bt > rem) bt = bt >> 2;
      while (bt != 0) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] pow2_frac(input logic [63:0] f);
      logic [63:0] acc;
      acc = 64'd1 << IG;
      for (int i = 1; i <= IG; i++) begin
         if (f[IG-i]) acc = (acc * half_roots[i]) >> IG;
      end
      return acc;
   endfunction

   function automatic logic [63:0] curve_value(input logic [63:0] maxv, input logic [63:0] a,
                                               input logic [63:0] b, input logic [63:0] u);
      logic [63:0] v, nv, fv, g, r, z, frac, t, e, n, w, wq, cap;
      int          p, sh;
      v   = '0;
      cap = 64'd32 << IG;
      if (a != 0) begin
         p    = 0;
         frac = '0;
         while (p < 62 && (u >> (p + 1)) != 0) p++;
         z = u << (IG - p);
         for (int i = 1; i <= IG; i++) begin
            z = (z * z) >> IG;
            if (z >= (64'd2 << IG)) begin
               z = z >> 1;
               frac = frac | (64'd1 << (IG - i));
            end
         end
         t = (64'(FRAC_BITS - p) << IG) - frac;
         e = (b * t) >> FRAC_BITS;
         n = e >> IG;
         if (n >= 37) begin
            w = cap;
         end else begin
            wq = (a * pow2_frac(e & ((64'd1 << IG) - 1))) >> FRAC_BITS;
            w  = (wq > (cap >> n)) ? cap : (wq << n);
         end
         v = (w >> IG) * 64'(LOG2E) + (((w & ((64'd1 << IG) - 1)) * 64'(LOG2E)) >> IG);
      end
      nv = v >> IG;
      fv = v & ((64'd1 << IG) - 1);
      if (nv >= 32) return 0;
      g  = (fv == 0) ? (64'd2 << IG) : pow2_frac((64'd1 << IG) - fv);
      sh = IG + 1 + int'(nv);
      r  = (maxv * g + (64'd1 << (sh - 1))) >> sh;
      return (r > 64'(ONE)) ? 64'(ONE) : r;
   endfunction

   function automatic perm_pair_type predict_perm(input logic [SAT_W-1:0] sw);
      perm_pair_type res;
      longint        span, num;
      logic [63:0]   wmax, omax, x;
      span = longint'(ONE) - longint'(irr_water) - longint'(res_oil);
      num  = longint'(sw) - longint'(irr_water);
      wmax = (water_max > ONE) ? 64'(ONE) : 64'(water_max);
      omax = (oil_max > ONE) ? 64'(ONE) : 64'(oil_max);
      if (span <= 0) begin
         res.water = '0;
         res.oil   = '0;
      end else if (num <= 0) begin
         res.water = '0;
         res.oil   = omax[SAT_W-1:0];
      end else if (num >= span) begin
         res.water = wmax[SAT_W-1:0];
         res.oil   = '0;
      end else begin
         x = (64'(num) << FRAC_BITS) / 64'(span);
         res.water = SAT_W'(curve_value(wmax, water_a, water_b, x));
         res.oil   = SAT_W'(curve_value(omax, oil_a, oil_b, 64'(ONE) - x));
      end
      return res;
   endfunction

   initial begin
      logic [63:0] r;
      r = 64'd2 << IG;
      for (int i = 1; i <= IG; i++) begin
         r = floor_sqrt(r << IG);
         half_roots[i] = r;
      end
   end

   assign pending = perm_queue.size();

   always @(posedge clock) begin
      perm_pair_type exp_pair;
      if (reset) begin
         water_a <= '0; water_b <= '0; oil_a <= '0; oil_b <= '0;
         irr_water <= '0; res_oil <= '0; water_max <= '0; oil_max <= '0;
         perm_queue.delete();
         failures <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_WATER_A:   water_a   <= csr_wdata;
               CSR_WATER_B:   water_b   <= csr_wdata;
               CSR_OIL_A:     oil_a     <= csr_wdata;
               CSR_OIL_B:     oil_b     <= csr_wdata;
               CSR_IRR_WATER: irr_water <= csr_wdata[SAT_W-1:0];
               CSR_RES_OIL:   res_oil   <= csr_wdata[SAT_W-1:0];
               CSR_WATER_END: water_max <= csr_wdata[SAT_W-1:0];
               CSR_OIL_END:   oil_max   <= csr_wdata[SAT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) perm_queue.push_back(predict_perm(req_water_saturation));
         if (rsp_valid && rsp_ready) begin
            if (perm_queue.size() == 0) begin
               $display("%0t: unexpected word water=%0d oil=%0d", $time,
                        rsp_water_rel_perm, rsp_oil_rel_perm);
               failures <= failures + 1;
            end else begin
               exp_pair = perm_queue.pop_front();
               if (exp_pair.water !== rsp_water_rel_perm ||
                   exp_pair.oil !== rsp_oil_rel_perm) begin
                  $display("%0t: mismatch water exp %0d got %0d, oil exp %0d got %0d",
                           $time, exp_pair.water, rsp_water_rel_perm,
                           exp_pair.oil, rsp_oil_rel_perm);
                  failures <= failures + 1;
               end
            end
         end
      end
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative permeability curves: testbench top
// Drives directed and random saturation words through several curve and
// saturation-limit settings with random stalls on both channels; the checker
// predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import rpc_pkg::*;

   localparam int DRAIN_CYCLES = 130;
   localparam int STALL_LIMIT  = 3000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [SAT_W-1:0]     req_water_saturation;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [SAT_W-1:0]     rsp_water_rel_perm;
   logic [SAT_W-1:0]     rsp_oil_rel_perm;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_wdata;
   int                   failures;
   int                   pending;
   int                   quiet_cycles;
   int                   hold_count;
   bit                   no_idle;

   relative_permeability_curves_top i_dut (.*);

   rpc_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int gap_len();
      if (no_idle) return 0;
      if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 2));
      return int'($urandom_range(8, 40));
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_count <= 0;
      end else if (hold_count > 0) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count - 1;
      end else begin
         rsp_ready  <= 1'b1;
         hold_count <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [COEF_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic load_curves(input logic [COEF_W-1:0] wa, input logic [COEF_W-1:0] wb,
                              input logic [COEF_W-1:0] oa, input logic [COEF_W-1:0] ob,
                              input logic [SAT_W-1:0] swirr, input logic [SAT_W-1:0] sor,
                              input logic [SAT_W-1:0] wend, input logic [SAT_W-1:0] oend);
      write_reg(CSR_WATER_A, wa);
      write_reg(CSR_WATER_B, wb);
      write_reg(CSR_OIL_A, oa);
      write_reg(CSR_OIL_B, ob);
      write_reg(CSR_IRR_WATER, COEF_W'(swirr));
      write_reg(CSR_RES_OIL, COEF_W'(sor));
      write_reg(CSR_WATER_END, COEF_W'(wend));
      write_reg(CSR_OIL_END, COEF_W'(oend));
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      drop_valid();
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_word(input logic [SAT_W-1:0] sw);
      int gap;
      gap = gap_len();
      @(negedge clock);
      req_valid            <= 1'b1;
      req_water_saturation <= sw;
      do @(posedge clock); while (!req_ready);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic [COEF_W-1:0] pick_coeff();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return COEF_W'($urandom_range(0, 24'hFFFFFF));
         default: return COEF_W'($urandom_range(4096, 4 * 65536));
      endcase
   endfunction

   function automatic logic [SAT_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ONE;
         default: return SAT_W'($urandom_range(0, 24000));
      endcase
   endfunction

   function automatic logic [SAT_W-1:0] pick_endpoint();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return ONE;
         2: return SAT_W'($urandom_range(65537, 131071));
         default: return SAT_W'($urandom_range(0, 65536));
      endcase
   endfunction

   initial begin
      logic [SAT_W-1:0] swirr, sor;
      logic [SAT_W-1:0] probe_words [11];
      int               span;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_water_saturation = '0;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      no_idle              = 1'b0;
      probe_words          = '{17'd0, 17'd13107, 17'd13108, 17'd58981, 17'd58982,
                               17'd65536, 17'h1FFFF, 17'd32768, 17'd1, 17'h15555,
                               17'h0AAAA};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: zero endpoints
      send_word(17'd0);
      send_word(17'd32768);
      send_word(17'h1FFFF);
      wait_idle();

      load_curves(24'd65536, 24'd65536, 24'd131072, 24'd32768,
                  17'd13107, 17'd6554, ONE, 17'd52428);
      foreach (probe_words[i])
         send_word(probe_words[i]);
      wait_idle();

      // no span left, then flat curves with endpoints above one
      load_curves(24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, ONE, 17'd0, 17'h1FFFF, 17'h1FFFF);
      send_word(17'd0);
      send_word(17'd65536);
      wait_idle();
      write_reg(CSR_IRR_WATER, 24'd0);
      send_word(17'd1);
      send_word(17'd40000);
      send_word(17'd65535);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         swirr = pick_limit();
         sor   = pick_limit();
         load_curves(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                     swirr, sor, pick_endpoint(), pick_endpoint());
         span    = int'(ONE) - int'(swirr) - int'(sor);
         no_idle = (phase % 3 == 1);
         for (int k = 0; k < 50; k++) begin
            if (k == 25) begin
               drop_valid();
               wait (pending == 0);
            end
            if (span > 0 && $urandom_range(0, 9) < 7)
               send_word(SAT_W'(int'(swirr) + $urandom_range(0, span)));
            else
               send_word(SAT_W'($urandom_range(0, 17'h1FFFF)));
         end
         wait_idle();
      end

      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
